@@ rtl/set_intersection_hash_table_core_defines.svh @@
// Assertion macros shared by the set intersection RTL.
`ifndef SET_INTERSECTION_HASH_TABLE_CORE_DEFINES_SVH
`define SET_INTERSECTION_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SIHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("siht check failed");

// Next-cycle implication, checked while out of reset.
`define SIHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("siht check failed");

`endif

@@ rtl/siht_pkg.sv @@
// Shared types and codes for the set intersection table block.
`default_nettype none
package siht_pkg;

  // operation field codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch input word, restart scan
    logic rd_en;     // read table entry at scan index
    logic compare;   // record match of the read entry
    logic step;      // advance scan index
    logic finish;    // update table and load result word
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;     // table holds no entries
    logic at_last;   // scan index is the last occupied entry
    logic match;     // read entry equals the latched value
    logic out_free;  // result register can take a word
  } status_t;

endpackage
`default_nettype wire

@@ rtl/set_intersection_hash_table_core.sv @@
// Set intersection core: one result word per input word, table scanned linearly.
// Each input word is held (in_stall high) until its scan is done and its result
//   word is loaded; a stalled output holds the finish, and an empty table skips the scan.
// The single read port of the table memory is read then compared once per
//   entry; the scan stops at the first match or at the last occupied entry.
// Reset (rst_n low, synchronous): table empty, no result pending.
`default_nettype none
module set_intersection_hash_table_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_emitted,
  output logic signed [31:0]      out_member_value,
  output logic                    out_table_full
);
  import siht_pkg::*;

  cmd_t    cmd;
  status_t status;

  siht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  siht_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_emitted      (out_emitted),
    .out_member_value (out_member_value),
    .out_table_full   (out_table_full),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
`default_nettype wire

@@ rtl/siht_ctrl.sv @@
// Sequencer for the linear table scan: accept, read/compare loop, finish.
`default_nettype none
`include "set_intersection_hash_table_core_defines.svh"
module siht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire siht_pkg::status_t status,
  output siht_pkg::cmd_t         cmd
);
  import siht_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = status.empty ? ST_FIN : ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        if (status.match || status.at_last) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SIHT_ASSERT_IMPL(a_finish_needs_slot, cmd.finish, status.out_free)
  `SIHT_ASSERT_NEXT(a_read_then_compare, cmd.rd_en, state_r == ST_CMP)
  `SIHT_ASSERT_NEXT(a_capture_leaves_idle, cmd.capture, state_r != ST_IDLE)

endmodule
`default_nettype wire

@@ rtl/siht_datapath.sv @@
// Table memory, scan index, fill count and result register.
`default_nettype none
`include "set_intersection_hash_table_core_defines.svh"
module siht_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_operation,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_emitted,
  output logic signed [31:0]      out_member_value,
  output logic                    out_table_full,
  input  wire siht_pkg::cmd_t     cmd,
  output siht_pkg::status_t       status
);
  import siht_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [63:0] VMASK = (VALUE_WIDTH >= 64) ? {64{1'b1}} :
                                  ((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  // table: unreported mark above the stored value
  logic [VALUE_WIDTH:0] mem [TABLE_DEPTH];

  logic                   op_r;
  logic [VALUE_WIDTH-1:0] v_r;
  logic                   last_r;
  logic [AW-1:0]          idx_r;
  logic                   hit_r;
  logic [CW-1:0]          count_r;
  logic [VALUE_WIDTH-1:0] rd_value_r;
  logic                   rd_unrep_r;

  logic                   out_valid_r;
  logic                   out_emitted_r;
  logic [31:0]            out_member_r;
  logic                   out_full_r;

  logic [63:0]            in_ext;
  logic [63:0]            v_zext;
  logic                   has_room;
  logic                   do_emit;
  logic                   do_insert;
  logic                   do_full;

  // sign-extend, then keep the table's value width
  assign in_ext   = 64'(in_value) & VMASK;
  assign v_zext   = 64'(v_r);
  assign has_room = (count_r < DEPTH_CNT);

  assign do_emit   = (op_r == OP_PROBE) && hit_r && rd_unrep_r;
  assign do_insert = (op_r == OP_LOAD) && !hit_r && has_room;
  assign do_full   = (op_r == OP_LOAD) && !hit_r && !has_room;

  assign status.empty    = (count_r == '0);
  assign status.at_last  = ((CW'(idx_r) + CW'(1)) == count_r);
  assign status.match    = (rd_value_r == v_r);
  assign status.out_free = !out_valid_r || !out_stall;

  // latched input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      v_r    <= in_ext[VALUE_WIDTH-1:0];
      last_r <= in_last;
    end
  end

  // scan index and match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.step) begin
          idx_r <= idx_r + AW'(1);
        end
        if (cmd.compare) begin
          hit_r <= status.match;
        end
      end
    end
  end

  // table read and write-back
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      {rd_unrep_r, rd_value_r} <= mem[idx_r];
    end
    if (cmd.finish && do_insert) begin
      mem[count_r[AW-1:0]] <= {1'b1, v_r};
    end else if (cmd.finish && do_emit) begin
      mem[idx_r] <= {1'b0, v_r};
    end
  end

  // fill count; last word empties the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      if (last_r) begin
        count_r <= '0;
      end else if (do_insert) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_emitted_r <= do_emit;
      out_member_r  <= do_emit ? v_zext[31:0] : 32'd0;
      out_full_r    <= do_full;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_emitted      = out_emitted_r;
  assign out_member_value = signed'(out_member_r);
  assign out_table_full   = out_full_r;

  `SIHT_ASSERT_IMPL(a_count_in_range, 1'b1, count_r <= DEPTH_CNT)
  `SIHT_ASSERT_NEXT(a_last_empties, cmd.finish && last_r, count_r == '0)
  `SIHT_ASSERT_IMPL(a_flags_exclusive, out_valid_r, !(out_emitted_r && out_full_r))

endmodule
`default_nettype wire
